/* rtl/rrv_pkg.sv */
// ----------------------------------------------------------------------------
// rrv_pkg
// Shared types and constants for the redundant replica voter.
// ----------------------------------------------------------------------------
package rrv_pkg;

    // fixed field widths
    localparam int CNT_W  = 4;
    localparam int STAT_W = 13;

    // request kinds
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    // verdict codes
    localparam logic [1:0] VK_AGREED   = 2'd0;
    localparam logic [1:0] VK_FAILURES = 2'd1;
    localparam logic [1:0] VK_NOQUORUM = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_CHILD_COUNT    = 2'd0;
    localparam logic [1:0] REG_VOTE_THRESHOLD = 2'd1;

    // reset values of the configuration registers
    localparam logic [CNT_W-1:0] CHILD_COUNT_RST    = 4'd3;
    localparam logic [CNT_W-1:0] VOTE_THRESHOLD_RST = 4'd2;

    // i/o error code
    localparam logic signed [STAT_W-1:0] NEG_EIO = -13'sd5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic             vote_clr;
        logic             cnt_clr;
        logic             rd;
        logic             post;
        logic             cmp;
        logic             cand_end;
        logic             post_cmp;
        logic             finish;
        logic [CNT_W-1:0] i;
        logic [CNT_W-1:0] j;
    } rrv_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic             req_done;
        logic             skip;
        logic             elig_i;
        logic             found;
        logic             out_free;
        logic [CNT_W-1:0] n_eff;
    } rrv_stat_t;

endpackage

/* rtl/rrv_ctrl.sv */
// ----------------------------------------------------------------------------
// rrv_ctrl
// Sequencer: collection, candidate vote loops, post pass and verdict load.
// ----------------------------------------------------------------------------
module rrv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  rrv_pkg::rrv_stat_t st,
    output rrv_pkg::rrv_cmd_t  cmd,
    output logic              collecting
);
    import rrv_pkg::*;

    localparam logic [3:0] S_COLLECT = 4'd0;
    localparam logic [3:0] S_VINIT   = 4'd1;
    localparam logic [3:0] S_CAND    = 4'd2;
    localparam logic [3:0] S_RD      = 4'd3;
    localparam logic [3:0] S_CMP     = 4'd4;
    localparam logic [3:0] S_CEND    = 4'd5;
    localparam logic [3:0] S_PRD     = 4'd6;
    localparam logic [3:0] S_PCMP    = 4'd7;
    localparam logic [3:0] S_FINISH  = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] n_last;

    assign n_last     = st.n_eff - 4'd1;
    assign collecting = (state_reg == S_COLLECT);

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cmd          = '0;
        cmd.i        = i_reg;
        cmd.j        = j_reg;
        case (state_reg)
            S_COLLECT:
            begin
                if (st.req_done)
                    state_next = S_VINIT;
            end
            S_VINIT:
            begin
                cmd.vote_clr = 1'b1;
                i_next       = '0;
                state_next   = st.skip ? S_FINISH : S_CAND;
            end
            S_CAND:
            begin
                if (i_reg == st.n_eff)
                begin
                    j_next     = '0;
                    state_next = st.found ? S_PRD : S_FINISH;
                end
                else if (st.elig_i)
                begin
                    cmd.cnt_clr = 1'b1;
                    j_next      = '0;
                    state_next  = S_RD;
                end
                else
                begin
                    i_next = i_reg + 4'd1;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                if (j_reg == n_last)
                    state_next = S_CEND;
                else
                begin
                    j_next     = j_reg + 4'd1;
                    state_next = S_RD;
                end
            end
            S_CEND:
            begin
                cmd.cand_end = 1'b1;
                i_next       = i_reg + 4'd1;
                state_next   = S_CAND;
            end
            S_PRD:
            begin
                cmd.rd     = 1'b1;
                cmd.post   = 1'b1;
                state_next = S_PCMP;
            end
            S_PCMP:
            begin
                cmd.post_cmp = 1'b1;
                if (j_reg == n_last)
                    state_next = S_FINISH;
                else
                begin
                    j_next     = j_reg + 4'd1;
                    state_next = S_PRD;
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

endmodule

/* rtl/rrv_datapath.sv */
// ----------------------------------------------------------------------------
// rrv_datapath
// Replica store, request tallies, vote accumulators and verdict register.
// ----------------------------------------------------------------------------
module rrv_datapath #(
    parameter int MAX_CHILDREN = 8,
    parameter int DIGEST_BITS  = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [rrv_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic                          in_take,
    input  logic [1:0]                    action,
    input  logic [2:0]                    child_index,
    input  logic signed [rrv_pkg::STAT_W-1:0] child_status,
    input  logic [63:0]                   content_digest,
    input  logic                          out_stall,
    input  rrv_pkg::rrv_cmd_t             cmd,
    output rrv_pkg::rrv_stat_t            st,
    output logic                          out_valid,
    output logic signed [rrv_pkg::STAT_W-1:0] final_status,
    output logic [1:0]                    verdict_kind,
    output logic [2:0]                    source_child,
    output logic [rrv_pkg::CNT_W-1:0]     winner_votes,
    output logic [7:0]                    bad_child_mask,
    output logic [rrv_pkg::CNT_W-1:0]     success_total
);
    import rrv_pkg::*;

    localparam int IW = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
    localparam int MW = STAT_W + DIGEST_BITS;

    // configuration
    logic [CNT_W-1:0] child_count_reg, vote_threshold_reg;
    logic [CNT_W-1:0] n_eff, thr;

    // request tallies
    logic [MAX_CHILDREN-1:0] arrived_reg, fail_reg;
    logic [CNT_W-1:0]        arrival_count_reg, success_count_reg;
    logic [1:0]              act_reg;

    // replica store
    logic [MW-1:0] mem [MAX_CHILDREN];
    logic [MW-1:0] rd_a_reg, rd_b_reg;

    // vote accumulators
    logic [CNT_W-1:0]        count_reg, best_reg;
    logic                    seen_reg, found_reg;
    logic [IW-1:0]           wi_reg;
    logic [MAX_CHILDREN-1:0] bad_reg;
    logic [STAT_W-1:0]       fstat_reg;

    // verdict register
    logic                    out_valid_reg;
    logic [STAT_W-1:0]       o_stat_reg;
    logic [1:0]              o_kind_reg;
    logic [2:0]              o_src_reg;
    logic [CNT_W-1:0]        o_votes_reg, o_succ_reg;
    logic [MAX_CHILDREN-1:0] o_bad_reg;

    logic [IW-1:0]           widx, ib, jb, addr_a;
    logic                    take_ok, is_flush, fail_path, sel_digest, eq;
    logic [MAX_CHILDREN-1:0] good, elig;
    logic [STAT_W-1:0]       v_stat;
    logic [1:0]              v_kind;
    logic [2:0]              v_src;
    logic [CNT_W-1:0]        v_votes;
    logic [MAX_CHILDREN-1:0] v_bad;

    // effective count and threshold
    always_comb
    begin
        if (child_count_reg == '0)
            n_eff = 4'd1;
        else if (int'(child_count_reg) > MAX_CHILDREN)
            n_eff = CNT_W'(MAX_CHILDREN);
        else
            n_eff = child_count_reg;
    end
    assign thr = (vote_threshold_reg == '0) ? 4'd1 : vote_threshold_reg;

    // completion filter
    assign widx    = IW'({1'b0, child_index});
    assign take_ok = in_take && ({1'b0, child_index} < n_eff) && !arrived_reg[widx];

    // vote mode
    assign is_flush   = (act_reg == ACT_FLUSH);
    assign fail_path  = !is_flush && (success_count_reg < thr);
    assign sel_digest = !is_flush && !fail_path && (act_reg == ACT_READ);
    assign good       = arrived_reg & ~fail_reg;
    assign elig       = is_flush ? arrived_reg : (fail_path ? fail_reg : good);

    assign ib     = cmd.i[IW-1:0];
    assign jb     = cmd.j[IW-1:0];
    assign addr_a = cmd.post ? wi_reg : ib;

    // compare the two read values on the selected field
    assign eq = sel_digest ? (rd_a_reg[DIGEST_BITS-1:0] == rd_b_reg[DIGEST_BITS-1:0])
                           : (rd_a_reg[MW-1:DIGEST_BITS] == rd_b_reg[MW-1:DIGEST_BITS]);

    // status to the controller
    always_comb
    begin
        st.req_done = take_ok && ((arrival_count_reg + 4'd1) == n_eff);
        st.skip     = !is_flush && !fail_path && (act_reg != ACT_READ);
        st.elig_i   = elig[ib];
        st.found    = found_reg;
        st.out_free = !out_valid_reg || !out_stall;
        st.n_eff    = n_eff;
    end

    // verdict from the finished vote
    always_comb
    begin
        v_stat  = found_reg ? fstat_reg : '0;
        v_kind  = VK_AGREED;
        v_src   = '0;
        v_votes = best_reg;
        v_bad   = fail_reg;
        if (is_flush)
        begin
            v_kind = (v_stat == '0) ? VK_AGREED : VK_FAILURES;
        end
        else if (fail_path)
        begin
            v_kind = VK_FAILURES;
        end
        else if (act_reg != ACT_READ)
        begin
            v_stat  = '0;
            v_votes = success_count_reg;
        end
        else
        begin
            v_bad = bad_reg;
            if (best_reg < thr)
            begin
                v_kind = VK_NOQUORUM;
                v_stat = NEG_EIO;
            end
            else
            begin
                v_stat = '0;
                v_src  = 3'(wi_reg);
            end
        end
    end

    // replica store write
    always_ff @(posedge clk)
    begin
        if (take_ok)
            mem[widx] <= {child_status, content_digest[DIGEST_BITS-1:0]};
    end

    // replica store read ports
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[jb];
        end
    end

    // configuration and request tallies
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            child_count_reg    <= CHILD_COUNT_RST;
            vote_threshold_reg <= VOTE_THRESHOLD_RST;
            arrived_reg        <= '0;
            fail_reg           <= '0;
            arrival_count_reg  <= '0;
            success_count_reg  <= '0;
            act_reg            <= ACT_READ;
        end
        else
        begin
            if (take_ok)
            begin
                if (arrival_count_reg == '0)
                    act_reg <= action;
                arrived_reg[widx]  <= 1'b1;
                fail_reg[widx]     <= (child_status != '0);
                arrival_count_reg  <= arrival_count_reg + 4'd1;
                if (child_status == '0)
                    success_count_reg <= success_count_reg + 4'd1;
            end
            if (cmd.finish)
            begin
                arrived_reg       <= '0;
                fail_reg          <= '0;
                arrival_count_reg <= '0;
                success_count_reg <= '0;
            end
            if (cfg_we && cfg_index == REG_CHILD_COUNT)
            begin
                child_count_reg   <= cfg_wdata;
                arrived_reg       <= '0;
                fail_reg          <= '0;
                arrival_count_reg <= '0;
                success_count_reg <= '0;
            end
            if (cfg_we && cfg_index == REG_VOTE_THRESHOLD)
                vote_threshold_reg <= cfg_wdata;
        end
    end

    // vote accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            best_reg  <= '0;
            seen_reg  <= 1'b0;
            found_reg <= 1'b0;
            wi_reg    <= '0;
            bad_reg   <= '0;
            fstat_reg <= '0;
        end
        else
        begin
            if (cmd.vote_clr)
            begin
                best_reg  <= '0;
                found_reg <= 1'b0;
                wi_reg    <= '0;
                bad_reg   <= fail_reg;
            end
            if (cmd.cnt_clr)
            begin
                count_reg <= '0;
                seen_reg  <= 1'b0;
            end
            if (cmd.cmp && elig[jb] && eq)
            begin
                count_reg <= count_reg + 4'd1;
                if (cmd.j < cmd.i)
                    seen_reg <= 1'b1;
            end
            // first occurrence with a count at least the best so far wins
            if (cmd.cand_end && !seen_reg && count_reg >= best_reg)
            begin
                best_reg  <= count_reg;
                wi_reg    <= ib;
                found_reg <= 1'b1;
            end
            if (cmd.post_cmp)
            begin
                fstat_reg <= rd_a_reg[MW-1:DIGEST_BITS];
                if (sel_digest && good[jb] && !eq)
                    bad_reg[jb] <= 1'b1;
            end
        end
    end

    // verdict register handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // verdict payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            o_stat_reg  <= v_stat;
            o_kind_reg  <= v_kind;
            o_src_reg   <= v_src;
            o_votes_reg <= v_votes;
            o_bad_reg   <= v_bad;
            o_succ_reg  <= success_count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign final_status  = o_stat_reg;
    assign verdict_kind  = o_kind_reg;
    assign source_child  = o_src_reg;
    assign winner_votes  = o_votes_reg;
    assign success_total = o_succ_reg;

    // map the replica mask onto the 8-bit port
    for (genvar k = 0; k < 8; k++)
    begin : g_bad
        if (k < MAX_CHILDREN)
        begin : g_on
            assign bad_child_mask[k] = o_bad_reg[k];
        end
        else
        begin : g_off
            assign bad_child_mask[k] = 1'b0;
        end
    end

endmodule

/* rtl/redundant_replica_voter.sv */
// ----------------------------------------------------------------------------
// redundant_replica_voter
// Majority voter over replica completions of one request.
// ----------------------------------------------------------------------------
// Completions are taken one per cycle while a request is collecting. After
// the child_count-th distinct replica reports, the input stalls while the
// vote runs over the replica store through one compare unit with two
// registered read ports. A write that has enough successes skips the vote.
// The verdict sits in an output register; collection of the next request
// starts while it waits.
// ----------------------------------------------------------------------------
module redundant_replica_voter #(
    parameter int MAX_CHILDREN = 8,
    parameter int DIGEST_BITS  = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [rrv_pkg::CNT_W-1:0]         cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        action,
    input  logic [2:0]                        child_index,
    input  logic signed [rrv_pkg::STAT_W-1:0] child_status,
    input  logic [63:0]                       content_digest,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [rrv_pkg::STAT_W-1:0] final_status,
    output logic [1:0]                        verdict_kind,
    output logic [2:0]                        source_child,
    output logic [rrv_pkg::CNT_W-1:0]         winner_votes,
    output logic [7:0]                        bad_child_mask,
    output logic [rrv_pkg::CNT_W-1:0]         success_total
);
    import rrv_pkg::*;

    rrv_cmd_t  cmd;
    rrv_stat_t st;
    logic      collecting;

    assign in_stall = !collecting;

    // sequencer
    rrv_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .st         (st),
        .cmd        (cmd),
        .collecting (collecting)
    );

    // store, tallies and verdict
    rrv_datapath #(
        .MAX_CHILDREN (MAX_CHILDREN),
        .DIGEST_BITS  (DIGEST_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_take        (in_valid && collecting),
        .action         (action),
        .child_index    (child_index),
        .child_status   (child_status),
        .content_digest (content_digest),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (out_valid),
        .final_status   (final_status),
        .verdict_kind   (verdict_kind),
        .source_child   (source_child),
        .winner_votes   (winner_votes),
        .bad_child_mask (bad_child_mask),
        .success_total  (success_total)
    );

    // no quorum always reports the i/o error
    a_noquorum_eio: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict_kind == VK_NOQUORUM |-> final_status == NEG_EIO)
        else $error("no-quorum verdict without i/o error status");

    // only an agreed read names a source replica
    a_src_agreed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict_kind != VK_AGREED |-> source_child == 3'd0)
        else $error("source replica on a non-agreed verdict");

    // an agreed verdict is a success
    a_agreed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict_kind == VK_AGREED |-> final_status == '0)
        else $error("agreed verdict with error status");

endmodule

/* dv/tb_redundant_replica_voter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_redundant_replica_voter
// Drives replica completions into the voter and checks every verdict.
// Each accepted completion goes through a behavioral vote model that queues
// the verdict due. A directed table covers extremes, ties, repeated and
// out-of-range replicas. Random requests follow under several register
// settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_redundant_replica_voter;
    import rrv_pkg::*;

    localparam int NMAX    = 8;
    localparam int WD_LIMIT = 20000;
    localparam int DRAIN    = 200;

    typedef struct packed {
        logic signed [STAT_W-1:0] fstat;
        logic [1:0]               kind;
        logic [2:0]               src;
        logic [CNT_W-1:0]         votes;
        logic [7:0]               bad;
        logic [CNT_W-1:0]         succ;
    } verdict_t;

    typedef struct {
        logic [1:0]               act;
        logic [2:0]               idx;
        logic signed [STAT_W-1:0] st;
        logic [63:0]              dg;
        bit                       has_exp;
        verdict_t                 exp;
    } row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [1:0]               cfg_index = '0;
    logic [CNT_W-1:0]         cfg_wdata = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               action = '0;
    logic [2:0]               child_index = '0;
    logic signed [STAT_W-1:0] child_status = '0;
    logic [63:0]              content_digest = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [STAT_W-1:0] final_status;
    logic [1:0]               verdict_kind;
    logic [2:0]               source_child;
    logic [CNT_W-1:0]         winner_votes;
    logic [7:0]               bad_child_mask;
    logic [CNT_W-1:0]         success_total;

    // model state
    logic [CNT_W-1:0]         m_count;
    logic [CNT_W-1:0]         m_thr;
    logic [STAT_W-1:0]        m_status [NMAX];
    logic [63:0]              m_digest [NMAX];
    logic [7:0]               m_arrived;
    int                       m_arrivals;
    int                       m_succ;
    logic [1:0]               m_act;

    verdict_t pending_verdicts[$];
    int       errors = 0;
    int       idle_cycles = 0;
    bit       quiet = 1'b0;

    redundant_replica_voter u_dut (.*);

    always #5 clk = ~clk;

    // vote over eligible replicas; ties go to the distinct value seen latest
    function automatic void tally(input logic [63:0] vals [NMAX], input logic [7:0] elig,
                                  input int n, output int win, output int cnt,
                                  output bit found);
        int c;
        bit dup;
        win = 0; cnt = 0; found = 0;
        for (int i = 0; i < n; i++)
        begin
            if (!elig[i]) continue;
            dup = 0;
            for (int j = 0; j < i; j++)
                if (elig[j] && vals[j] == vals[i]) dup = 1;
            if (dup) continue;
            c = 0;
            for (int j = i; j < n; j++)
                if (elig[j] && vals[j] == vals[i]) c++;
            if (c >= cnt)
            begin
                cnt = c; win = i; found = 1;
            end
        end
    endfunction

    function automatic int eff_count();
        if (m_count == 0) return 1;
        if (m_count > NMAX) return NMAX;
        return m_count;
    endfunction

    // accepts one completion; returns 1 with the verdict when a request closes
    function automatic bit vote_step(input logic [1:0] act, input logic [2:0] idx,
                                     input logic [STAT_W-1:0] st, input logic [63:0] dg,
                                     output verdict_t v);
        int n, thr, wi, wc;
        bit found;
        logic [7:0] fail, good;
        logic [63:0] vals [NMAX];
        n = eff_count();
        thr = (m_thr == 0) ? 1 : m_thr;
        v = '0;
        if (idx >= n || m_arrived[idx]) return 0;
        if (m_arrivals == 0) m_act = act;
        m_status[idx] = st;
        m_digest[idx] = dg;
        m_arrived[idx] = 1'b1;
        m_arrivals++;
        if (st == 0) m_succ++;
        if (m_arrivals < n) return 0;
        fail = '0;
        for (int i = 0; i < NMAX; i++)
        begin
            vals[i] = (i < n) ? 64'(m_status[i]) : 64'd0;
            if (i < n && m_status[i] != 0) fail[i] = 1'b1;
        end
        good = m_arrived & ~fail;
        v.bad = fail;
        if (m_act == ACT_FLUSH)
        begin
            tally(vals, m_arrived, n, wi, wc, found);
            if (found) v.fstat = m_status[wi];
            v.votes = CNT_W'(wc);
            v.kind = (v.fstat == 0) ? VK_AGREED : VK_FAILURES;
        end
        else if (m_succ < thr)
        begin
            v.kind = VK_FAILURES;
            tally(vals, fail, n, wi, wc, found);
            if (found)
            begin
                v.fstat = m_status[wi];
                v.votes = CNT_W'(wc);
            end
        end
        else if (m_act != ACT_READ)
            v.votes = CNT_W'(m_succ);
        else
        begin
            for (int i = 0; i < n; i++) vals[i] = m_digest[i];
            tally(vals, good, n, wi, wc, found);
            v.votes = CNT_W'(wc);
            for (int i = 0; i < n; i++)
                if (good[i] && vals[i] != vals[wi]) v.bad[i] = 1'b1;
            if (wc < thr)
            begin
                v.kind = VK_NOQUORUM;
                v.fstat = NEG_EIO;
            end
            else
                v.src = 3'(wi);
        end
        v.succ = CNT_W'(m_succ);
        m_arrived = '0; m_arrivals = 0; m_succ = 0;
        return 1;
    endfunction

    // watchdog on accepted transactions
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // verdict checker
    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected verdict status=%0d", final_status);
                errors++;
            end
            else
            begin
                e = pending_verdicts.pop_front();
                if (final_status !== e.fstat)
                begin
                    $error("final_status exp %0d got %0d", e.fstat, final_status); errors++;
                end
                if (verdict_kind !== e.kind)
                begin
                    $error("verdict_kind exp %0d got %0d", e.kind, verdict_kind); errors++;
                end
                if (source_child !== e.src)
                begin
                    $error("source_child exp %0d got %0d", e.src, source_child); errors++;
                end
                if (winner_votes !== e.votes)
                begin
                    $error("winner_votes exp %0d got %0d", e.votes, winner_votes); errors++;
                end
                if (bad_child_mask !== e.bad)
                begin
                    $error("bad_child_mask exp %h got %h", e.bad, bad_child_mask); errors++;
                end
                if (success_total !== e.succ)
                begin
                    $error("success_total exp %0d got %0d", e.succ, success_total); errors++;
                end
            end
        end
    end

    // receiver stall
    always @(negedge clk)
        out_stall <= (!quiet && $urandom_range(0, 99) < 10);

    task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CHILD_COUNT)
        begin
            m_count = val;
            m_arrived = '0; m_arrivals = 0; m_succ = 0;
        end
        else if (idx == REG_VOTE_THRESHOLD)
            m_thr = val;
    endtask

    // wait until all verdicts are in and the vote engine has settled
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // send one completion, entered at a falling edge; returns at a falling edge
    // with valid still up, so the next call or settle decides what follows
    task automatic send(input logic [1:0] act, input logic [2:0] idx,
                        input logic signed [STAT_W-1:0] st, input logic [63:0] dg,
                        input bit has_exp, input verdict_t exp);
        verdict_t v;
        while (!quiet && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1; action <= act; child_index <= idx;
        child_status <= st; content_digest <= dg;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (vote_step(act, idx, st, dg, v))
        begin
            if (has_exp && v !== exp)
            begin
                $error("directed row: model verdict %h, table %h", v, exp);
                errors++;
            end
            pending_verdicts.push_back(v);
        end
        @(negedge clk);
    endtask

    function automatic row_t mk(input logic [1:0] a, input logic [2:0] i,
                                input int s, input logic [63:0] d);
        row_t r;
        r.act = a; r.idx = i; r.st = STAT_W'(s); r.dg = d; r.has_exp = 0; r.exp = '0;
        return r;
    endfunction

    function automatic row_t mke(input logic [1:0] a, input logic [2:0] i, input int s,
                                 input logic [63:0] d, input verdict_t e);
        row_t r;
        r = mk(a, i, s, d);
        r.has_exp = 1; r.exp = e;
        return r;
    endfunction

    // random request: mostly well formed, some noise
    task automatic random_request(input int n);
        logic [1:0] act;
        logic [63:0] pool [3];
        int order [NMAX];
        int k, t;
        verdict_t none;
        none = '0;
        act = 2'($urandom_range(0, 3));
        for (int i = 0; i < 3; i++) pool[i] = {$urandom, $urandom};
        for (int i = 0; i < n; i++) order[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            k = $urandom_range(0, i); t = order[i]; order[i] = order[k]; order[k] = t;
        end
        for (int i = 0; i < n; i++)
        begin
            int st;
            logic [63:0] dg;
            case ($urandom_range(0, 5))
                0: st = -int'($urandom_range(1, 4095));
                1: st = -int'($urandom_range(1, 3));
                default: st = 0;
            endcase
            dg = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : pool[$urandom_range(0, 2)];
            // occasional repeated or out-of-range replica
            if ($urandom_range(0, 15) == 0)
                send(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                     STAT_W'(-int'($urandom_range(0, 4095))),
                     {$urandom, $urandom}, 0, none);
            send(($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : act,
                 3'(order[i]), STAT_W'(st), dg, 0, none);
        end
    endtask

    initial
    begin
        row_t rows[$];
        verdict_t e;
        int n;
        int settings [6][2] = '{'{3, 2}, '{8, 8}, '{1, 1}, '{0, 0}, '{15, 5}, '{5, 3}};
        m_count = CHILD_COUNT_RST; m_thr = VOTE_THRESHOLD_RST;
        m_arrived = '0; m_arrivals = 0; m_succ = 0; m_act = ACT_READ;
        for (int i = 0; i < NMAX; i++)
        begin
            m_status[i] = '0; m_digest[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table at reset settings (3 replicas, threshold 2)
        e = '{fstat: 0, kind: VK_AGREED, src: 0, votes: 3, bad: 0, succ: 3};
        rows.push_back(mk(ACT_READ, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
        rows.push_back(mk(ACT_READ, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF));
        rows.push_back(mke(ACT_READ, 2, 0, 64'hFFFF_FFFF_FFFF_FFFF, e));
        // all fail with the extreme code, repeated and out-of-range ignored
        e = '{fstat: -13'sd4095, kind: VK_FAILURES, src: 0, votes: 3, bad: 8'h07, succ: 0};
        rows.push_back(mk(ACT_WRITE, 2, -4095, 0));
        rows.push_back(mk(ACT_WRITE, 2, 0, 0));
        rows.push_back(mk(ACT_READ, 5, 0, 0));
        rows.push_back(mk(ACT_READ, 0, -4095, 0));
        rows.push_back(mke(ACT_FLUSH, 1, -4095, 0, e));
        // read no quorum: three distinct digests
        e = '{fstat: NEG_EIO, kind: VK_NOQUORUM, src: 0, votes: 1, bad: 8'h03, succ: 3};
        rows.push_back(mk(ACT_READ, 0, 0, 64'h1));
        rows.push_back(mk(ACT_READ, 1, 0, 64'h2));
        rows.push_back(mke(ACT_READ, 2, 0, 64'h3, e));
        // flush tie between zero and an error code goes to the later value
        rows.push_back(mk(ACT_FLUSH, 0, 0, 0));
        rows.push_back(mk(ACT_FLUSH, 1, -1, 0));
        rows.push_back(mk(ACT_FLUSH, 2, -2, 0));
        // write agreed with one failure, action three
        e = '{fstat: 0, kind: VK_AGREED, src: 0, votes: 2, bad: 8'h02, succ: 2};
        rows.push_back(mk(2'd3, 0, 0, 0));
        rows.push_back(mk(ACT_READ, 1, -5, 0));
        rows.push_back(mke(ACT_WRITE, 2, 0, 0, e));
        // read majority, source is the later replica
        rows.push_back(mk(ACT_READ, 0, 0, 64'hA5A5));
        rows.push_back(mk(ACT_READ, 2, 0, 64'h5A5A));
        rows.push_back(mk(ACT_READ, 1, 0, 64'h5A5A));
        foreach (rows[r])
            send(rows[r].act, rows[r].idx, rows[r].st, rows[r].dg, rows[r].has_exp, rows[r].exp);
        settle();

        // threshold above child count: failure with no error codes
        write_reg(REG_VOTE_THRESHOLD, 4'd15);
        e = '{fstat: 0, kind: VK_FAILURES, src: 0, votes: 0, bad: 0, succ: 3};
        send(ACT_WRITE, 0, 0, 0, 0, e);
        send(ACT_WRITE, 1, 0, 0, 0, e);
        send(ACT_WRITE, 2, 0, 0, 1, e);
        settle();

        // child count rewrite drops a partial request
        write_reg(REG_CHILD_COUNT, 4'd4);
        send(ACT_READ, 0, 0, 0, 0, e);
        settle();

        // random phases across settings, a quiet stretch in the middle
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_CHILD_COUNT, CNT_W'(settings[p][0]));
            write_reg(REG_VOTE_THRESHOLD, CNT_W'(settings[p][1]));
            quiet = (p == 2);
            n = eff_count();
            for (int k = 0; k < 200 / n + 4; k++)
                random_request(n);
            settle();
        end
        quiet = 1'b0;

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
